// ----- hdl/text_console_writer_assert.svh -----
// Assertion macros used by the checker file of the console writer.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCW_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/tcw_pkg.sv -----
package tcw_pkg;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELL_COUNT = COLS * ROWS;

  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  localparam int BYTE_W      = 8;
  localparam int CELL_W      = 2 * BYTE_W;
  localparam int FIELD_COL_W = 7;
  localparam int FIELD_ROW_W = 5;

  localparam logic [BYTE_W-1:0] NEWLINE_CHAR      = 8'd10;
  localparam logic [BYTE_W-1:0] DEFAULT_ATTR_RST  = 8'd15;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified command on its way from the front to the back end.
  typedef struct packed {
    logic              is_read;
    logic              is_newline;
    logic              at_cursor;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] attr;
  } cmd_t;

endpackage

// ----- hdl/tcw_if.sv -----
interface tcw_req_if import tcw_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [BYTE_W-1:0]      ch;
  logic [FIELD_COL_W-1:0] col;
  logic [FIELD_ROW_W-1:0] row;
  logic                   at_cursor;
  logic [BYTE_W-1:0]      attr;

  modport source (output valid, func, ch, col, row, at_cursor, attr, input ready);
  modport sink   (input valid, func, ch, col, row, at_cursor, attr, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [BYTE_W-1:0]      cell_char;
  logic [BYTE_W-1:0]      cell_attr;
  logic [FIELD_COL_W-1:0] cursor_col;
  logic [FIELD_ROW_W-1:0] cursor_row;
  logic                   scrolled;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                  input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                  output ready);
endinterface

// ----- hdl/tcw_front.sv -----
module tcw_front
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tcw_req_if.sink           req,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data,
  input  logic              init_busy,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_data
);

  logic [BYTE_W-1:0] default_attr;
  logic              is_read;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RST;
    end else if (cfg_valid && cfg_ready) begin
      default_attr <= cfg_data;
    end
  end

  assign req.ready = !init_busy && !q_full;
  assign push      = req.valid && req.ready;
  assign is_read   = (req.func == FUNC_READ);

  // Saturate coordinates, resolve the attribute, tag newlines.
  always_comb begin
    push_data.is_read    = is_read;
    push_data.is_newline = !is_read && (req.ch == NEWLINE_CHAR);
    push_data.at_cursor  = !is_read && req.at_cursor;
    push_data.col = (32'(req.col) >= COLS) ? COL_W'(COLS - 1) : COL_W'(req.col);
    push_data.row = (32'(req.row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(req.row);
    push_data.ch   = req.ch;
    push_data.attr = (req.attr == '0) ? default_attr : req.attr;
  end

endmodule

// ----- hdl/tcw_queue.sv -----
module tcw_queue
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_data
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/tcw_back.sv -----
module tcw_back
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_data,
  output logic q_pop,
  output logic init_busy,
  tcw_rsp_if.source rsp
);

  localparam logic [1:0] S_INIT   = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_SCROLL = 2'd3;

  logic [1:0]        state;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  top;
  logic [ADDR_W-1:0] clr_addr;
  logic [COL_W-1:0]  clr_cnt;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata;

  logic                   out_valid;
  logic [BYTE_W-1:0]      out_char;
  logic [BYTE_W-1:0]      out_attr;
  logic [FIELD_COL_W-1:0] out_col;
  logic [FIELD_ROW_W-1:0] out_row;
  logic                   out_scrolled;

  logic              slot_free;
  logic [COL_W-1:0]  pc;
  logic [ROW_W-1:0]  pr;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys_row;
  logic [ADDR_W-1:0] cell_addr;
  logic              wrap;
  logic              last_row;
  logic              do_scroll;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [ROW_W-1:0]  top_next;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  assign init_busy = (state == S_INIT);
  assign slot_free = !out_valid || rsp.ready;
  assign q_pop     = (state == S_IDLE) && q_valid && slot_free;

  // Target cell, mapped through the rotating top-row offset.
  always_comb begin
    pc        = q_data.at_cursor ? cur_col : q_data.col;
    pr        = q_data.at_cursor ? cur_row : q_data.row;
    row_sum   = {1'b0, pr} + {1'b0, top};
    phys_row  = (32'(row_sum) >= ROWS) ? ROW_W'(32'(row_sum) - ROWS) : ROW_W'(row_sum);
    cell_addr = ADDR_W'(32'(phys_row) * COLS) + ADDR_W'(pc);
  end

  always_comb begin
    wrap      = q_data.is_newline || (pc == COL_W'(COLS - 1));
    last_row  = (pr == ROW_W'(ROWS - 1));
    do_scroll = wrap && last_row;
    col_next  = wrap ? '0 : pc + 1'b1;
    row_next  = (wrap && !last_row) ? pr + 1'b1 : pr;
    top_next  = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    unique case (state) inside
      S_INIT, S_SCROLL: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_we    = q_pop && !q_data.is_read && !q_data.is_newline;
        mem_waddr = cell_addr;
        mem_wdata = {q_data.attr, q_data.ch};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_addr  <= '0;
      clr_cnt   <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            if (q_data.is_read) begin
              state <= S_READ;
            end else begin
              cur_col      <= col_next;
              cur_row      <= row_next;
              out_valid    <= 1'b1;
              out_char     <= '0;
              out_attr     <= '0;
              out_col      <= FIELD_COL_W'(col_next);
              out_row      <= FIELD_ROW_W'(row_next);
              out_scrolled <= do_scroll;
              if (do_scroll) begin
                top      <= top_next;
                clr_addr <= ADDR_W'(32'(top) * COLS);
                clr_cnt  <= '0;
                state    <= S_SCROLL;
              end
            end
          end
        end
        S_READ: begin
          out_valid    <= 1'b1;
          out_char     <= rdata[BYTE_W-1:0];
          out_attr     <= rdata[CELL_W-1:BYTE_W];
          out_col      <= FIELD_COL_W'(cur_col);
          out_row      <= FIELD_ROW_W'(cur_row);
          out_scrolled <= 1'b0;
          state        <= S_IDLE;
        end
        S_SCROLL: begin
          clr_addr <= clr_addr + 1'b1;
          clr_cnt  <= clr_cnt + 1'b1;
          if (clr_cnt == COL_W'(COLS - 1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cell_char  = out_char;
  assign rsp.cell_attr  = out_attr;
  assign rsp.cursor_col = out_col;
  assign rsp.cursor_row = out_row;
  assign rsp.scrolled   = out_scrolled;

endmodule

// ----- hdl/text_console_writer.sv -----
// Text console writer: a COLS x ROWS screen of character/attribute cells and a cursor.
// req channel: one command per transfer. func selects put or read; a put writes ch
//   with attr (zero attr selects default_attr) at col/row or, with at_cursor, at the
//   cursor, then advances the cursor; ch 10 only moves to the start of the next row.
// rsp channel: one transfer per command, carrying the read cell (zero for a put),
//   the cursor after the command and the scroll flag.
// cfg channel: writes default_attr; it is always ready.
// Order: a command passes through the queue, then the back end registers the result; a
//   read also passes through the screen memory's read register and the S_READ state.
// Rate: the back end retires a put per cycle while rsp is not stalled; a read holds it
//   in S_READ, and a put that scrolls holds it in S_SCROLL while it clears the new bottom
//   row, one cell per cycle through the single write port of the screen memory.
// Scrolling rotates a top-row offset, so no rows are copied.
// Reset: the cursor and offset go to zero and the whole screen memory of COLS * ROWS
//   (2000) cells is cleared, one cell per cycle; req.ready stays low meanwhile.
// Stall: a held rsp keeps its result; a two-entry queue lets req take up to two more
//   commands before req.ready drops.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tcw_req_if.sink           req,
  tcw_rsp_if.source         rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data
);

  logic init_busy;
  logic q_full;
  logic q_not_empty;
  logic push;
  logic pop;
  cmd_t push_data;
  cmd_t pop_data;

  // Front end: accept, saturate coordinates, resolve attribute.
  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple the front from a back end that stalls on reads and scrolls.
  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  // Back end: screen memory, cursor, scroll clearing and the result register.
  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .init_busy (init_busy),
    .rsp       (rsp)
  );

endmodule

// ----- hdl/tcw_checker.sv -----
`include "text_console_writer_assert.svh"

module tcw_checker
  import tcw_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [FIELD_COL_W-1:0] rsp_cursor_col,
  input logic [FIELD_ROW_W-1:0] rsp_cursor_row,
  input logic                   rsp_scrolled
);

  `TCW_ASSERT_RST(a_clear_after_reset, rst |=> !req_ready, "req ready during screen clear")

  `TCW_ASSERT(a_scroll_last_row, rsp_valid && rsp_scrolled |-> rsp_cursor_row == FIELD_ROW_W'(ROWS - 1), "scroll left cursor off last row")

  `TCW_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_col) && $stable(rsp_cursor_row) && $stable(rsp_scrolled), "stalled result changed")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_cursor_col (rsp.cursor_col),
  .rsp_cursor_row (rsp.cursor_row),
  .rsp_scrolled   (rsp.scrolled)
);
